[rtl/assert_macros.svh]
// Assertion macros included by geodetic_to_ecef.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(name, ck, rn, pre, post) \
    name: assert property (@(posedge ck) disable iff (!rn) (pre) |-> (post)) \
        else $error("implication check failed");

// next-cycle implication
`define ASSERT_NXT(name, ck, rn, pre, post) \
    name: assert property (@(posedge ck) disable iff (!rn) (pre) |=> (post)) \
        else $error("next-cycle check failed");

`endif

[rtl/g2e_pkg.sv]
// Types, constants and tables of the geodetic to ECEF converter.
package g2e_pkg;

    localparam int N_TERMS  = 10;
    localparam int N_NEWTON = 5;
    localparam int PIPE_LAT = 147;
    localparam int TRIG_DLY = 65;
    localparam int H_DLY    = 141;

    localparam logic [63:0] ONE_Q62   = 64'h4000_0000_0000_0000;
    localparam logic [63:0] THREE_Q62 = 64'hC000_0000_0000_0000;
    localparam logic [63:0] PI_Q62    = 64'hC90F_DAA2_2168_C235;
    localparam logic [63:0] E2_Q62    = 64'd30872378602522596;
    localparam logic [63:0] OMS_E2    = ONE_Q62 - E2_Q62;
    localparam logic [63:0] A_MM      = 64'd6378137000;
    localparam logic [63:0] MASK63    = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [64:0] TWO_64    = 65'h1_0000_0000_0000_0000;

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    localparam logic [8:0] SIN_DIV [N_TERMS] = '{
        9'd6, 9'd20, 9'd42, 9'd72, 9'd110, 9'd156, 9'd210, 9'd272, 9'd342, 9'd420};
    localparam logic [8:0] COS_DIV [N_TERMS] = '{
        9'd2, 9'd12, 9'd30, 9'd56, 9'd90, 9'd132, 9'd182, 9'd240, 9'd306, 9'd380};

    localparam logic [63:0] SIN_RCP [N_TERMS] = '{
        64'(TWO_64 / 65'd6),   64'(TWO_64 / 65'd20),  64'(TWO_64 / 65'd42),
        64'(TWO_64 / 65'd72),  64'(TWO_64 / 65'd110), 64'(TWO_64 / 65'd156),
        64'(TWO_64 / 65'd210), 64'(TWO_64 / 65'd272), 64'(TWO_64 / 65'd342),
        64'(TWO_64 / 65'd420)};
    localparam logic [63:0] COS_RCP [N_TERMS] = '{
        64'(TWO_64 / 65'd2),   64'(TWO_64 / 65'd12),  64'(TWO_64 / 65'd30),
        64'(TWO_64 / 65'd56),  64'(TWO_64 / 65'd90),  64'(TWO_64 / 65'd132),
        64'(TWO_64 / 65'd182), 64'(TWO_64 / 65'd240), 64'(TWO_64 / 65'd306),
        64'(TWO_64 / 65'd380)};

    typedef struct packed {
        logic signed [31:0] latitude;
        logic signed [31:0] longitude;
        logic signed [31:0] height;
    } geo_t;

    typedef struct packed {
        logic signed [35:0] ecef_x;
        logic signed [35:0] ecef_y;
        logic signed [35:0] ecef_z;
    } ecef_t;

    typedef struct packed {
        logic [63:0] x2;
        logic [63:0] ts;
        logic [63:0] tc;
        logic [63:0] ss;
        logic [63:0] cc;
        logic [1:0]  quad;
        logic        swap;
    } tay_t;

    typedef struct packed {
        logic [63:0] sin_mag;
        logic        sin_neg;
        logic [63:0] cos_mag;
        logic        cos_neg;
    } trig_t;

    typedef struct packed {
        logic [63:0] w;
        logic [63:0] y;
    } nwt_t;

endpackage

[rtl/g2e_mulr.sv]
// Three-stage 64x64 multiplier with optionally rounded right shift of the product.
module g2e_mulr (
    input  logic        clk,
    input  logic        en,
    input  logic [63:0] a,
    input  logic [63:0] b,
    input  logic [6:0]  sh,
    input  logic        rnd,
    output logic [63:0] p
);
    logic [63:0]  p00_reg, p01_reg, p10_reg, p11_reg;
    logic [127:0] sum_next, sum_reg;
    logic [127:0] half, rounded, shifted;
    logic [63:0]  p_next, p_reg;

    always_comb
    begin
        sum_next = {64'd0, p00_reg} + {32'd0, p01_reg, 32'd0}
                 + {32'd0, p10_reg, 32'd0} + {p11_reg, 64'd0};
        half     = rnd ? (128'd1 << (sh - 7'd1)) : 128'd0;
        rounded  = sum_reg + half;
        shifted  = rounded >> sh;
        p_next   = shifted[63:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p00_reg <= a[31:0]  * b[31:0];
            p01_reg <= a[31:0]  * b[63:32];
            p10_reg <= a[63:32] * b[31:0];
            p11_reg <= a[63:32] * b[63:32];
            sum_reg <= sum_next;
            p_reg   <= p_next;
        end
    end

    assign p = p_reg;
endmodule

[rtl/g2e_taylor_cell.sv]
// One Taylor term of sine and cosine: multiply by x^2, divide by a constant, accumulate.
module g2e_taylor_cell (
    input  logic          clk,
    input  logic          en,
    input  logic [8:0]    s_div,
    input  logic [8:0]    c_div,
    input  logic [63:0]   s_rcp,
    input  logic [63:0]   c_rcp,
    input  logic          add_term,
    input  g2e_pkg::tay_t tay_in,
    output g2e_pkg::tay_t tay_out
);
    import g2e_pkg::*;

    tay_t        tay_reg [6];
    tay_t        out_next, out_reg;
    logic [63:0] vs, vc, qs, qc;
    logic [63:0] vs_reg [3];
    logic [63:0] vc_reg [3];
    logic [15:0] rs, rc;
    logic [63:0] ts_new, tc_new;

    g2e_mulr u_vs (.clk(clk), .en(en), .a(tay_in.ts), .b(tay_in.x2), .sh(7'd62),
                   .rnd(1'b1), .p(vs));
    g2e_mulr u_vc (.clk(clk), .en(en), .a(tay_in.tc), .b(tay_in.x2), .sh(7'd62),
                   .rnd(1'b1), .p(vc));
    g2e_mulr u_qs (.clk(clk), .en(en), .a(vs), .b(s_rcp), .sh(7'd64),
                   .rnd(1'b0), .p(qs));
    g2e_mulr u_qc (.clk(clk), .en(en), .a(vc), .b(c_rcp), .sh(7'd64),
                   .rnd(1'b0), .p(qc));

    always_comb
    begin
        rs       = vs_reg[2][15:0] - 16'(qs[15:0] * {7'd0, s_div});
        rc       = vc_reg[2][15:0] - 16'(qc[15:0] * {7'd0, c_div});
        ts_new   = qs + 64'(rs >= {7'd0, s_div});
        tc_new   = qc + 64'(rc >= {7'd0, c_div});
        out_next = tay_reg[5];
        out_next.ts = ts_new;
        out_next.tc = tc_new;
        out_next.ss = add_term ? tay_reg[5].ss + ts_new : tay_reg[5].ss - ts_new;
        out_next.cc = add_term ? tay_reg[5].cc + tc_new : tay_reg[5].cc - tc_new;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tay_reg[0] <= tay_in;
            for (int i = 1; i < 6; i++)
            begin
                tay_reg[i] <= tay_reg[i-1];
            end
            vs_reg[0] <= vs;
            vc_reg[0] <= vc;
            for (int i = 1; i < 3; i++)
            begin
                vs_reg[i] <= vs_reg[i-1];
                vc_reg[i] <= vc_reg[i-1];
            end
            out_reg <= out_next;
        end
    end

    assign tay_out = out_reg;
endmodule

[rtl/g2e_sincos.sv]
// Sine and cosine of a 32-bit angle word through a row of Taylor cells.
module g2e_sincos (
    input  logic           clk,
    input  logic           en,
    input  logic [31:0]    ang,
    output g2e_pkg::trig_t trig
);
    import g2e_pkg::*;

    logic [30:0] r_reg;
    logic [29:0] res;
    logic        swap_now;
    logic [2:0]  qs_reg [7];
    logic [63:0] x, x2;
    logic [63:0] x_reg [3];
    tay_t        chain [N_TERMS+1];
    tay_t        fin;
    logic [63:0] s0, c0;
    trig_t       trig_next, trig_reg;

    assign res      = ang[29:0];
    assign swap_now = res > 30'h2000_0000;

    g2e_mulr u_x  (.clk(clk), .en(en), .a({33'd0, r_reg}), .b(PI_Q62), .sh(7'd31),
                   .rnd(1'b1), .p(x));
    g2e_mulr u_x2 (.clk(clk), .en(en), .a(x), .b(x), .sh(7'd62), .rnd(1'b1), .p(x2));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg     <= swap_now ? 31'h4000_0000 - {1'b0, res} : {1'b0, res};
            qs_reg[0] <= {ang[31:30], swap_now};
            for (int i = 1; i < 7; i++)
            begin
                qs_reg[i] <= qs_reg[i-1];
            end
            x_reg[0] <= x;
            for (int i = 1; i < 3; i++)
            begin
                x_reg[i] <= x_reg[i-1];
            end
            trig_reg <= trig_next;
        end
    end

    assign chain[0] = '{x2: x2, ts: x_reg[2], tc: ONE_Q62, ss: x_reg[2], cc: ONE_Q62,
                        quad: qs_reg[6][2:1], swap: qs_reg[6][0]};

    for (genvar k = 0; k < N_TERMS; k++)
    begin : g_cell
        g2e_taylor_cell u_cell (
            .clk      (clk),
            .en       (en),
            .s_div    (SIN_DIV[k]),
            .c_div    (COS_DIV[k]),
            .s_rcp    (SIN_RCP[k]),
            .c_rcp    (COS_RCP[k]),
            .add_term (1'(k % 2)),
            .tay_in   (chain[k]),
            .tay_out  (chain[k+1])
        );
    end

    always_comb
    begin
        fin = chain[N_TERMS];
        s0  = fin.swap ? fin.cc : fin.ss;
        c0  = fin.swap ? fin.ss : fin.cc;
        case (fin.quad)
            QUAD_0:  trig_next = '{sin_mag: s0, sin_neg: 1'b0, cos_mag: c0, cos_neg: 1'b0};
            QUAD_1:  trig_next = '{sin_mag: c0, sin_neg: 1'b0, cos_mag: s0, cos_neg: 1'b1};
            QUAD_2:  trig_next = '{sin_mag: s0, sin_neg: 1'b1, cos_mag: c0, cos_neg: 1'b1};
            QUAD_3:  trig_next = '{sin_mag: c0, sin_neg: 1'b1, cos_mag: s0, cos_neg: 1'b0};
            default: trig_next = '{sin_mag: s0, sin_neg: 1'b0, cos_mag: c0, cos_neg: 1'b0};
        endcase
    end

    assign trig = trig_reg;
endmodule

[rtl/g2e_newton_cell.sv]
// One Newton step of the inverse square root: y = y * (3 - w*y^2) / 2.
module g2e_newton_cell (
    input  logic          clk,
    input  logic          en,
    input  g2e_pkg::nwt_t nwt_in,
    output g2e_pkg::nwt_t nwt_out
);
    import g2e_pkg::*;

    nwt_t        nd_reg [7];
    logic [63:0] wd_reg [3];
    logic [63:0] ysq, wy2, d_reg, y_new;

    g2e_mulr u_ysq (.clk(clk), .en(en), .a(nwt_in.y), .b(nwt_in.y), .sh(7'd62),
                    .rnd(1'b1), .p(ysq));
    g2e_mulr u_wy2 (.clk(clk), .en(en), .a(nd_reg[2].w), .b(ysq), .sh(7'd62),
                    .rnd(1'b1), .p(wy2));
    g2e_mulr u_y   (.clk(clk), .en(en), .a(nd_reg[6].y), .b(d_reg), .sh(7'd63),
                    .rnd(1'b1), .p(y_new));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nd_reg[0] <= nwt_in;
            for (int i = 1; i < 7; i++)
            begin
                nd_reg[i] <= nd_reg[i-1];
            end
            wd_reg[0] <= nd_reg[6].w;
            for (int i = 1; i < 3; i++)
            begin
                wd_reg[i] <= wd_reg[i-1];
            end
            d_reg <= THREE_Q62 - wy2;
        end
    end

    assign nwt_out = '{w: wd_reg[2], y: y_new};
endmodule

[rtl/geodetic_to_ecef.sv]
// Throughput: one item per cycle while the skid stage is empty; the depth is set
// by the rows of Taylor cells and Newton cells, each built from three-stage
// 64x64 multipliers. A two-entry output register and skid stage take a result
// while the consumer stalls. Reset clears only the valid flags; the datapath
// registers are not reset.
`include "assert_macros.svh"

module geodetic_to_ecef (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           geo_valid,
    output logic           geo_ready,
    input  g2e_pkg::geo_t  geo,
    output logic           ecef_valid,
    input  logic           ecef_ready,
    output g2e_pkg::ecef_t ecef
);
    import g2e_pkg::*;

    typedef struct packed {
        trig_t lat;
        trig_t lon;
    } trig_pair_t;

    typedef struct packed {
        logic x;
        logic y;
        logic z;
    } sgn_t;

    logic                en, take;
    logic [PIPE_LAT-1:0] vld_reg;
    trig_t               lat_trig, lon_trig;
    trig_pair_t          trig_reg [TRIG_DLY];
    logic signed [31:0]  h_reg [H_DLY];
    logic [63:0]         s2, e2s2, w_reg, nq, mp, tp, xp, yp, zp;
    nwt_t                nchain [N_NEWTON+1];
    logic [63:0]         lq_reg, lmag_reg, mq_reg, mqmag_reg;
    logic                lneg_reg, mqneg_reg;
    logic                tneg_reg [3];
    sgn_t                sgn_reg [3];
    sgn_t                sgn_next;
    ecef_t               fin_reg;
    ecef_t               out_reg, skid_reg;
    logic                out_valid_reg, skid_valid_reg;

    function automatic logic [35:0] to_field(input logic [63:0] m, input logic neg);
        logic [63:0] mm;
        logic [43:0] r;
        mm = (m & MASK63) + 64'h8_0000;
        r  = mm[63:20];
        return neg ? 36'(44'd0 - r) : r[35:0];
    endfunction

    function automatic logic [63:0] hq(input logic signed [31:0] h);
        return {{12{h[31]}}, h, 20'd0};
    endfunction

    assign en        = !skid_valid_reg;
    assign geo_ready = en;
    assign take      = en && vld_reg[PIPE_LAT-1];

    g2e_sincos u_lat (.clk(clk), .en(en), .ang(geo.latitude), .trig(lat_trig));
    g2e_sincos u_lon (.clk(clk), .en(en), .ang(geo.longitude), .trig(lon_trig));

    g2e_mulr u_sq (.clk(clk), .en(en), .a(lat_trig.sin_mag), .b(lat_trig.sin_mag),
                   .sh(7'd62), .rnd(1'b1), .p(s2));
    g2e_mulr u_e2 (.clk(clk), .en(en), .a(E2_Q62), .b(s2), .sh(7'd62), .rnd(1'b1),
                   .p(e2s2));

    assign nchain[0] = '{w: w_reg, y: ONE_Q62};

    for (genvar k = 0; k < N_NEWTON; k++)
    begin : g_nwt
        g2e_newton_cell u_cell (.clk(clk), .en(en), .nwt_in(nchain[k]),
                                .nwt_out(nchain[k+1]));
    end

    g2e_mulr u_n (.clk(clk), .en(en), .a(A_MM), .b(nchain[N_NEWTON].y), .sh(7'd42),
                  .rnd(1'b1), .p(nq));
    g2e_mulr u_m (.clk(clk), .en(en), .a(OMS_E2), .b(nq), .sh(7'd62), .rnd(1'b1),
                  .p(mp));
    g2e_mulr u_t (.clk(clk), .en(en), .a(lmag_reg), .b(trig_reg[61].lat.cos_mag),
                  .sh(7'd62), .rnd(1'b1), .p(tp));
    g2e_mulr u_x (.clk(clk), .en(en), .a(tp & MASK63), .b(trig_reg[64].lon.cos_mag),
                  .sh(7'd62), .rnd(1'b1), .p(xp));
    g2e_mulr u_y (.clk(clk), .en(en), .a(tp & MASK63), .b(trig_reg[64].lon.sin_mag),
                  .sh(7'd62), .rnd(1'b1), .p(yp));
    g2e_mulr u_z (.clk(clk), .en(en), .a(mqmag_reg), .b(trig_reg[64].lat.sin_mag),
                  .sh(7'd62), .rnd(1'b1), .p(zp));

    always_comb
    begin
        sgn_next.x = tneg_reg[2] ^ trig_reg[64].lon.cos_neg;
        sgn_next.y = tneg_reg[2] ^ trig_reg[64].lon.sin_neg;
        sgn_next.z = mqneg_reg ^ trig_reg[64].lat.sin_neg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            trig_reg[0] <= '{lat: lat_trig, lon: lon_trig};
            for (int i = 1; i < TRIG_DLY; i++)
            begin
                trig_reg[i] <= trig_reg[i-1];
            end
            h_reg[0] <= geo.height;
            for (int i = 1; i < H_DLY; i++)
            begin
                h_reg[i] <= h_reg[i-1];
            end
            w_reg       <= ONE_Q62 - e2s2;
            lq_reg      <= nq + hq(h_reg[137]);
            lneg_reg    <= lq_reg[63];
            lmag_reg    <= lq_reg[63] ? 64'd0 - lq_reg : lq_reg;
            tneg_reg[0] <= lneg_reg ^ trig_reg[61].lat.cos_neg;
            tneg_reg[1] <= tneg_reg[0];
            tneg_reg[2] <= tneg_reg[1];
            mq_reg      <= mp + hq(h_reg[140]);
            mqneg_reg   <= mq_reg[63];
            mqmag_reg   <= mq_reg[63] ? 64'd0 - mq_reg : mq_reg;
            sgn_reg[0]  <= sgn_next;
            sgn_reg[1]  <= sgn_reg[0];
            sgn_reg[2]  <= sgn_reg[1];
            fin_reg.ecef_x <= to_field(xp, sgn_reg[2].x);
            fin_reg.ecef_y <= to_field(yp, sgn_reg[2].y);
            fin_reg.ecef_z <= to_field(zp, sgn_reg[2].z);
        end
    end

    // advance valid flags with the datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[PIPE_LAT-2:0], geo_valid};
        end
    end

    // output register with skid stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || ecef_ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= take;
            end
        end
        else if (take)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || ecef_ready)
        begin
            out_reg <= skid_valid_reg ? skid_reg : fin_reg;
        end
        else if (take)
        begin
            skid_reg <= fin_reg;
        end
    end

    assign ecef_valid = out_valid_reg;
    assign ecef       = out_reg;

    `ASSERT_IMP(a_skid_needs_out, clk, rst_n, skid_valid_reg, out_valid_reg)
    `ASSERT_NXT(a_stall_fills_skid, clk, rst_n, out_valid_reg && !ecef_ready && take,
                skid_valid_reg)
    `ASSERT_NXT(a_skid_drains, clk, rst_n, skid_valid_reg && ecef_ready,
                out_valid_reg && !skid_valid_reg)
endmodule
